FILE: rtl/m3inv_pkg.sv
// shared types, constants and index helpers for the 3x3 matrix inverse
`timescale 1ns / 1ps
package m3inv_pkg;

    localparam int DATA_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;
    localparam int DIM            = 3;
    localparam int NELEM          = 9;
    localparam int OUT_FRAC       = 16;
    localparam int ADDR_W         = 4;
    localparam int IN_W           = 16;
    localparam int OUT_W          = 32;
    localparam int QW             = OUT_W + 1;

    localparam logic [QW-1:0] LIMIT_POS = 33'h0_7FFF_FFFF;
    localparam logic [QW-1:0] LIMIT_NEG = 33'h0_8000_0000;

    // operand selects for the cofactor products
    localparam logic [1:0] SEL_R0C0 = 2'd0;
    localparam logic [1:0] SEL_R1C1 = 2'd1;
    localparam logic [1:0] SEL_R0C1 = 2'd2;
    localparam logic [1:0] SEL_R1C0 = 2'd3;

    typedef enum logic [3:0] {
        S_LOAD,
        S_COF_A,
        S_COF_B,
        S_COF_C,
        S_DET_A,
        S_DET_B,
        S_DIV_INIT,
        S_DIV_STEP,
        S_EMIT
    } state_t;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LOAD,
        OP_COF_A,
        OP_COF_B,
        OP_COF_C,
        OP_DET_A,
        OP_DET_B,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [ADDR_W-1:0] idx;
    } dp_cmd_t;

    typedef struct packed {
        logic det_zero;
        logic out_free;
    } dp_status_t;

    // row and column of a cell index 0..8
    function automatic logic [1:0] cell_row(input logic [ADDR_W-1:0] k);
        logic [1:0] r;
        if (k >= 4'd6)
            r = 2'd2;
        else if (k >= 4'd3)
            r = 2'd1;
        else
            r = 2'd0;
        return r;
    endfunction

    function automatic logic [1:0] cell_col(input logic [ADDR_W-1:0] k);
        logic [ADDR_W-1:0] c;
        if (k >= 4'd6)
            c = k - 4'd6;
        else if (k >= 4'd3)
            c = k - 4'd3;
        else
            c = k;
        return c[1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [1:0] r, input logic [1:0] c);
        return ({2'b00, r} << 1) + {2'b00, r} + {2'b00, c};
    endfunction

    // element address for one operand of the minor of cell k
    function automatic logic [ADDR_W-1:0] cof_addr(input logic [ADDR_W-1:0] k,
                                                   input logic [1:0] sel);
        logic [1:0]        i;
        logic [1:0]        j;
        logic [1:0]        r0;
        logic [1:0]        r1;
        logic [1:0]        c0;
        logic [1:0]        c1;
        logic [ADDR_W-1:0] a;
        i  = cell_row(k);
        j  = cell_col(k);
        r0 = (i == 2'd0) ? 2'd1 : 2'd0;
        r1 = (i == 2'd2) ? 2'd1 : 2'd2;
        c0 = (j == 2'd0) ? 2'd1 : 2'd0;
        c1 = (j == 2'd2) ? 2'd1 : 2'd2;
        unique case (sel)
            SEL_R0C0: a = cell_addr(r0, c0);
            SEL_R1C1: a = cell_addr(r1, c1);
            SEL_R0C1: a = cell_addr(r0, c1);
            SEL_R1C0: a = cell_addr(r1, c0);
            default:  a = cell_addr(r0, c0);
        endcase
        return a;
    endfunction

    // transposed position: cofactor (i, j) lands in adjugate (j, i)
    function automatic logic [ADDR_W-1:0] adj_dst(input logic [ADDR_W-1:0] k);
        return cell_addr(cell_col(k), cell_row(k));
    endfunction

    function automatic logic cof_neg(input logic [ADDR_W-1:0] k);
        logic [1:0] i;
        logic [1:0] j;
        i = cell_row(k);
        j = cell_col(k);
        return i[0] ^ j[0];
    endfunction

endpackage

FILE: rtl/m3inv_ram.sv
// generic single write, single registered read ram
`timescale 1ns / 1ps
module m3inv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 9
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/m3inv_dp.sv
// datapath: element store, cofactor and determinant multiply, bit-serial divider, output register
`timescale 1ns / 1ps
module m3inv_dp
    import m3inv_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  dp_cmd_t          cmd,
    output dp_status_t       status,
    input  logic [IN_W-1:0]  elem_in,
    input  logic             out_ready,
    output logic             out_valid,
    output logic [OUT_W-1:0] out_value,
    output logic             out_last,
    output logic             out_singular,
    output logic             out_overflow
);

    localparam int W    = DATA_WIDTH;
    localparam int CW   = 2 * W + 1;
    localparam int PW   = W + CW;
    localparam int DETW = 3 * W + 3;
    localparam int SHW  = FRAC_BITS + OUT_FRAC;
    localparam int NUMW = CW + SHW;

    // element conversion
    logic [W-1:0] elem;
    generate
        if (W <= IN_W)
        begin : g_narrow
            assign elem = elem_in[W-1:0];
        end
        else
        begin : g_wide
            assign elem = {{(W - IN_W){1'b0}}, elem_in};
        end
    endgenerate

    // two copies of the element store give two read ports
    logic              ram_we;
    logic [ADDR_W-1:0] raddr_a;
    logic [ADDR_W-1:0] raddr_b;
    logic [W-1:0]      rdata_a;
    logic [W-1:0]      rdata_b;

    assign ram_we = (cmd.op == OP_LOAD);

    m3inv_ram #(.WIDTH(W), .DEPTH(NELEM)) u_ram_a (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cmd.idx),
        .wdata (elem),
        .raddr (raddr_a),
        .rdata (rdata_a)
    );

    m3inv_ram #(.WIDTH(W), .DEPTH(NELEM)) u_ram_b (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cmd.idx),
        .wdata (elem),
        .raddr (raddr_b),
        .rdata (rdata_b)
    );

    // read address selection
    always_comb
    begin
        raddr_a = cof_addr(cmd.idx, SEL_R0C0);
        raddr_b = cof_addr(cmd.idx, SEL_R1C1);
        unique case (cmd.op)
            OP_COF_B:
            begin
                raddr_a = cof_addr(cmd.idx, SEL_R0C1);
                raddr_b = cof_addr(cmd.idx, SEL_R1C0);
            end
            OP_DET_A:
            begin
                raddr_a = cmd.idx;
                raddr_b = cmd.idx;
            end
            default:
            begin
                raddr_a = cof_addr(cmd.idx, SEL_R0C0);
                raddr_b = cof_addr(cmd.idx, SEL_R1C1);
            end
        endcase
    end

    // adjugate registers and determinant
    logic signed [CW-1:0]   adj_reg [NELEM];
    logic signed [CW-1:0]   p1_reg;
    logic signed [DETW-1:0] det_reg;
    logic [ADDR_W-1:0]      adj_rd;
    logic signed [CW-1:0]   adj_val;

    assign adj_rd  = (cmd.op == OP_DET_B) ? ((cmd.idx << 1) + cmd.idx) : cmd.idx;
    assign adj_val = adj_reg[adj_rd];

    // shared multiplier
    logic signed [W-1:0]  mul_a;
    logic signed [CW-1:0] mul_b;
    logic signed [PW-1:0] mul_p;
    logic signed [CW-1:0] cof_diff;
    logic signed [CW-1:0] cof_val;

    assign mul_a    = rdata_a;
    assign mul_b    = (cmd.op == OP_DET_B) ? adj_val : CW'($signed(rdata_b));
    assign mul_p    = mul_a * mul_b;
    assign cof_diff = p1_reg - mul_p[CW-1:0];
    assign cof_val  = cof_neg(cmd.idx) ? -cof_diff : cof_diff;

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_COF_B)
        begin
            p1_reg <= mul_p[CW-1:0];
        end
        if (cmd.op == OP_COF_C)
        begin
            adj_reg[adj_dst(cmd.idx)] <= cof_val;
        end
        if (cmd.op == OP_COF_A && cmd.idx == '0)
        begin
            det_reg <= '0;
        end
        else if (cmd.op == OP_DET_B)
        begin
            det_reg <= det_reg + DETW'(mul_p);
        end
    end

    // magnitudes for the divider
    logic [CW-1:0]   na;
    logic [DETW-1:0] nd;
    logic            det_zero;

    assign na       = adj_val[CW-1] ? CW'(-adj_val) : CW'(adj_val);
    assign nd       = det_reg[DETW-1] ? DETW'(-det_reg) : DETW'(det_reg);
    assign det_zero = (det_reg == '0);

    // restoring divider, one quotient bit per cycle
    logic [NUMW-1:0] num_reg;
    logic [DETW-1:0] rem_reg;
    logic [QW-1:0]   q_reg;
    logic            sticky_reg;
    logic            neg_reg;
    logic [DETW:0]   rs;
    logic            ge;

    assign rs = {rem_reg, num_reg[NUMW-1]};
    assign ge = (rs >= {1'b0, nd});

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_DIV_INIT)
        begin
            num_reg    <= {na, {SHW{1'b0}}};
            rem_reg    <= '0;
            q_reg      <= '0;
            sticky_reg <= 1'b0;
            neg_reg    <= adj_val[CW-1] ^ det_reg[DETW-1];
        end
        else if (cmd.op == OP_DIV_STEP)
        begin
            num_reg    <= num_reg << 1;
            rem_reg    <= ge ? DETW'(rs - {1'b0, nd}) : rs[DETW-1:0];
            q_reg      <= {q_reg[QW-2:0], ge};
            sticky_reg <= sticky_reg | q_reg[QW-1];
        end
    end

    // saturation and sign
    logic [QW-1:0]    limit;
    logic             ovf;
    logic [QW-1:0]    mag;
    logic [QW-1:0]    sval;
    logic [OUT_W-1:0] res_value;

    assign limit     = neg_reg ? LIMIT_NEG : LIMIT_POS;
    assign ovf       = sticky_reg | (q_reg > limit);
    assign mag       = ovf ? limit : q_reg;
    assign sval      = neg_reg ? -mag : mag;
    assign res_value = det_zero ? '0 : sval[OUT_W-1:0];

    // output register
    logic out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.op == OP_EMIT)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_EMIT)
        begin
            out_value    <= res_value;
            out_last     <= (cmd.idx == ADDR_W'(NELEM - 1));
            out_singular <= det_zero;
            out_overflow <= ~det_zero & ovf;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status.det_zero = det_zero;
    assign status.out_free = ~out_valid_reg | out_ready;

endmodule

FILE: rtl/m3inv_ctrl.sv
// controller: sequences loading, cofactors, determinant, divides and result hand-off
`timescale 1ns / 1ps
module m3inv_ctrl
    import m3inv_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    localparam int NUMW  = 2 * DATA_WIDTH + 1 + FRAC_BITS + OUT_FRAC;
    localparam int BCW   = $clog2(NUMW + 1);
    localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(NELEM - 1);
    localparam logic [ADDR_W-1:0] LAST_DET = ADDR_W'(DIM - 1);
    localparam logic [BCW-1:0]    LAST_BIT = BCW'(NUMW - 1);

    state_t            state_reg;
    state_t            state_next;
    logic [ADDR_W-1:0] idx_reg;
    logic [ADDR_W-1:0] idx_next;
    logic [BCW-1:0]    bit_reg;
    logic [BCW-1:0]    bit_next;

    // state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            idx_reg   <= '0;
            bit_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            bit_reg   <= bit_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        bit_next   = bit_reg;
        unique case (state_reg)
            S_LOAD:
            begin
                if (in_valid)
                begin
                    if (idx_reg == LAST_IDX)
                    begin
                        idx_next   = '0;
                        state_next = S_COF_A;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            S_COF_A:
            begin
                state_next = S_COF_B;
            end
            S_COF_B:
            begin
                state_next = S_COF_C;
            end
            S_COF_C:
            begin
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = S_DET_A;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_COF_A;
                end
            end
            S_DET_A:
            begin
                state_next = S_DET_B;
            end
            S_DET_B:
            begin
                if (idx_reg == LAST_DET)
                begin
                    idx_next   = '0;
                    state_next = S_DIV_INIT;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_DET_A;
                end
            end
            S_DIV_INIT:
            begin
                bit_next   = '0;
                state_next = status.det_zero ? S_EMIT : S_DIV_STEP;
            end
            S_DIV_STEP:
            begin
                if (bit_reg == LAST_BIT)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    bit_next = bit_reg + 1'b1;
                end
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    if (idx_reg == LAST_IDX)
                    begin
                        idx_next   = '0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_DIV_INIT;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // datapath commands
    always_comb
    begin
        in_ready = 1'b0;
        cmd.idx  = idx_reg;
        cmd.op   = OP_IDLE;
        unique case (state_reg)
            S_LOAD:
            begin
                in_ready = 1'b1;
                cmd.op   = in_valid ? OP_LOAD : OP_IDLE;
            end
            S_COF_A:    cmd.op = OP_COF_A;
            S_COF_B:    cmd.op = OP_COF_B;
            S_COF_C:    cmd.op = OP_COF_C;
            S_DET_A:    cmd.op = OP_DET_A;
            S_DET_B:    cmd.op = OP_DET_B;
            S_DIV_INIT: cmd.op = OP_DIV_INIT;
            S_DIV_STEP: cmd.op = OP_DIV_STEP;
            S_EMIT:     cmd.op = status.out_free ? OP_EMIT : OP_IDLE;
            default:    cmd.op = OP_IDLE;
        endcase
    end

endmodule

FILE: rtl/matrix3x3_inverse.sv
// top level of the 3x3 matrix inverse by the adjugate method
`timescale 1ns / 1ps
// Takes nine signed Q8.8 elements in row-major order and returns the nine
// Q16.16 elements of the inverse in row-major order, tlast on the ninth.
// A zero determinant gives zero results flagged singular; quotients that do
// not fit Q16.16 saturate and are flagged overflow. A matrix is loaded,
// then its cofactors and determinant are formed on one shared multiplier,
// then each result passes through the bit-serial divider (skipped when
// singular) and waits out any output stall. Input is taken only during
// loading; the next matrix can load while the last result waits.
module matrix3x3_inverse
    import m3inv_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,   // [15:0] elem_value
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata,   // [31:0] inv_value
    output logic             m_axis_tlast,
    output logic [1:0]       m_axis_tuser    // [0] singular, [1] overflow
);

    dp_cmd_t    cmd;
    dp_status_t status;

    m3inv_ctrl #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    m3inv_dp #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .elem_in      (s_axis_tdata),
        .out_ready    (m_axis_tready),
        .out_valid    (m_axis_tvalid),
        .out_value    (m_axis_tdata),
        .out_last     (m_axis_tlast),
        .out_singular (m_axis_tuser[0]),
        .out_overflow (m_axis_tuser[1])
    );

    // singular results are zero and never flagged overflow
    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0 && !m_axis_tuser[1])
        else $error("singular result not zero");

    // a waiting result holds until it is taken
    a_hold_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // no result is produced while elements are still being loaded
    a_no_emit_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |-> cmd.op != OP_EMIT)
        else $error("emit during load");

endmodule
